### hw/rtl/awtnt_pkg.sv
// Package for the ADC window threshold note trigger.
// Holds register indexes, reset values, the configuration and message
// structs and the byte selector enum; depends on nothing.
package awtnt_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int SUM_W       = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DISCARD   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STATUS    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_NOTE      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_VELOCITY  = 3'd5;

	localparam logic [15:0] THRESHOLD_RST = 16'hFE4A;
	localparam logic [3:0]  DISCARD_RST   = 4'd4;
	localparam logic [4:0]  WINDOW_RST    = 5'd1;
	localparam logic [7:0]  STATUS_RST    = 8'h99;
	localparam logic [6:0]  NOTE_RST      = 7'h24;
	localparam logic [6:0]  VELOCITY_RST  = 7'h45;

	localparam logic [SUM_W-1:0] SUM_MAX = 16'h7FFF;
	localparam logic [SUM_W-1:0] SUM_MIN = 16'h8000;

	typedef struct packed {
		logic signed [15:0] threshold;
		logic [3:0]         discard;
		logic [4:0]         window;
		logic [7:0]         status;
		logic [6:0]         note;
		logic [6:0]         velocity;
	} cfg_t;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] note;
		logic [6:0] velocity;
	} msg_t;

	typedef enum logic [1:0] {
		SEL_STATUS,
		SEL_NOTE,
		SEL_VELOCITY
	} sel_t;

endpackage

### hw/rtl/adc_window_threshold_note_trigger.sv
// ADC window threshold note trigger: top level with configuration registers.
// Instantiates awtnt_front, awtnt_queue and awtnt_back; uses awtnt_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall, conversion_ready, adc_sample): one
//   transaction per ADC status read. Transactions with conversion_ready low
//   are taken and ignored. Discarded samples and window sums are handled in
//   the cycle of acceptance; a new transaction may be offered every cycle.
//   Output channel (out_valid / out_stall, midi_byte, last_byte): a note-on
//   leaves as three transactions (status, note, velocity), last_byte set on
//   the velocity byte. The status byte passes through the message queue and
//   the output register after the input transaction that closed the window;
//   the following bytes come one a cycle while the receiver does not stall.
//   Throughput: one input transaction per cycle while in_stall is low. Each
//   message takes three output bytes, so a run of closely spaced notes can
//   outpace the byte stream. A two-entry message queue sits between the
//   front end and the byte register, so in_stall rises only while two
//   messages are in the queue (the older one possibly part sent).
//   Receiver stall: hold the current byte in the output register; the front
//   end keeps taking samples until the queue fills.
//   Configuration: cfg_write with cfg_index and cfg_data, only while idle;
//   unknown indexes are dropped.
//   Reset: arst_n clears counters, the window sum, the queue and the output
//   valid flag, re-arms the trigger and loads the default register values.
module adc_window_threshold_note_trigger
	import awtnt_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int MAX_WINDOW  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          conversion_ready,
	input  logic signed [SAMPLE_BITS-1:0] adc_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    midi_byte,
	output logic                          last_byte
);

	cfg_t cfg_q;
	logic q_full;
	logic q_not_empty;
	logic push;
	logic pop;
	msg_t push_msg;
	msg_t q_head;

	// Register file: decode the index and keep only the register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RST;
			cfg_q.discard   <= DISCARD_RST;
			cfg_q.window    <= WINDOW_RST;
			cfg_q.status    <= STATUS_RST;
			cfg_q.note      <= NOTE_RST;
			cfg_q.velocity  <= VELOCITY_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_THRESHOLD: cfg_q.threshold <= cfg_data;
				CFG_DISCARD:   cfg_q.discard   <= cfg_data[3:0];
				CFG_WINDOW:    cfg_q.window    <= cfg_data[4:0];
				CFG_STATUS:    cfg_q.status    <= cfg_data[7:0];
				CFG_NOTE:      cfg_q.note      <= cfg_data[6:0];
				CFG_VELOCITY:  cfg_q.velocity  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Front end: window accounting and the trigger decision.
	awtnt_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_WINDOW  (MAX_WINDOW)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.conversion_ready (conversion_ready),
		.adc_sample       (adc_sample),
		.q_full           (q_full),
		.push             (push),
		.push_msg         (push_msg)
	);

	// Decouple the trigger from the byte stream.
	awtnt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_msg  (push_msg),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Back end: three bytes per message through the output register.
	awtnt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.midi_byte   (midi_byte),
		.last_byte   (last_byte)
	);

endmodule

### hw/rtl/awtnt_front.sv
// Front end: accepts ADC transactions, discards, sums and compares a window,
// and pushes a note-on message into the queue. Depends on awtnt_pkg.
module awtnt_front
	import awtnt_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int MAX_WINDOW  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          conversion_ready,
	input  logic signed [SAMPLE_BITS-1:0] adc_sample,
	input  logic                          q_full,
	output logic                          push,
	output msg_t                          push_msg
);

	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int LW = ((CW > 5) ? CW : 5) + 1;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_WINDOW);

	logic [3:0]       discard_cnt_q;
	logic [CW-1:0]    window_cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic             held_q;

	logic                    take;
	logic                    discarding;
	logic [SUM_W:0]          sample_ext;
	logic [SUM_W:0]          sum_wide;
	logic signed [SUM_W-1:0] sum_sat;
	logic [LW-1:0]           len;
	logic [LW-1:0]           cnt_next;
	logic                    win_done;
	logic                    fire;
	logic                    rearm;

	assign in_stall = q_full;
	assign take     = in_valid && !in_stall && conversion_ready;

	assign discarding = discard_cnt_q < cfg.discard;

	assign sample_ext = {{(SUM_W + 1 - SAMPLE_BITS){adc_sample[SAMPLE_BITS-1]}}, adc_sample};
	assign sum_wide   = {sum_q[SUM_W-1], sum_q} + sample_ext;

	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	// Zero-length window counts as one; clamp long windows to the maximum.
	always_comb begin
		if (cfg.window == 5'd0) begin
			len = LW'(1);
		end else if (LW'(cfg.window) > MAX_LEN) begin
			len = MAX_LEN;
		end else begin
			len = LW'(cfg.window);
		end
	end

	assign cnt_next = LW'(window_cnt_q) + LW'(1);
	assign win_done = cnt_next >= len;
	assign fire     = win_done && (sum_sat < cfg.threshold) && !held_q;
	assign rearm    = win_done && (sum_sat > cfg.threshold);

	assign push              = take && !discarding && fire;
	assign push_msg.status   = cfg.status;
	assign push_msg.note     = cfg.note;
	assign push_msg.velocity = cfg.velocity;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discard_cnt_q <= '0;
			window_cnt_q  <= '0;
			sum_q         <= '0;
			held_q        <= 1'b0;
		end else if (take) begin
			if (discarding) begin
				discard_cnt_q <= discard_cnt_q + 4'd1;
			end else if (win_done) begin
				discard_cnt_q <= '0;
				window_cnt_q  <= '0;
				sum_q         <= '0;
				if (fire) begin
					held_q <= 1'b1;
				end else if (rearm) begin
					held_q <= 1'b0;
				end
			end else begin
				window_cnt_q <= cnt_next[CW-1:0];
				sum_q        <= sum_sat;
			end
		end
	end

endmodule

### hw/rtl/awtnt_queue.sv
// Two-entry message queue between the front end and the byte serialiser.
// Depends on awtnt_pkg.
module awtnt_queue
	import awtnt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  msg_t push_msg,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output msg_t head
);

	msg_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### hw/rtl/awtnt_back.sv
// Back end: serialises each queued message into three MIDI bytes through an
// output register. Depends on awtnt_pkg.
module awtnt_back
	import awtnt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  msg_t       q_head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] midi_byte,
	output logic       last_byte
);

	sel_t       sel_q;
	sel_t       sel_next;
	logic       load;
	logic [7:0] byte_next;
	logic       last_next;
	logic       out_valid_q;
	logic [7:0] midi_byte_q;
	logic       last_byte_q;

	assign load = q_not_empty && (!out_valid_q || !out_stall);

	always_comb begin
		sel_next = sel_q;
		if (load) begin
			unique case (sel_q)
				SEL_STATUS:   sel_next = SEL_NOTE;
				SEL_NOTE:     sel_next = SEL_VELOCITY;
				SEL_VELOCITY: sel_next = SEL_STATUS;
				default:      sel_next = SEL_STATUS;
			endcase
		end
	end

	always_comb begin
		byte_next = q_head.status;
		last_next = 1'b0;
		unique case (sel_q)
			SEL_STATUS: begin
				byte_next = q_head.status;
				last_next = 1'b0;
			end
			SEL_NOTE: begin
				byte_next = {1'b0, q_head.note};
				last_next = 1'b0;
			end
			SEL_VELOCITY: begin
				byte_next = {1'b0, q_head.velocity};
				last_next = 1'b1;
			end
			default: begin
				byte_next = q_head.status;
				last_next = 1'b0;
			end
		endcase
	end

	// Release the queue entry once its final byte is loaded.
	assign pop = load && last_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= SEL_STATUS;
			out_valid_q <= 1'b0;
		end else begin
			sel_q <= sel_next;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			midi_byte_q <= byte_next;
			last_byte_q <= last_next;
		end
	end

	assign out_valid = out_valid_q;
	assign midi_byte = midi_byte_q;
	assign last_byte = last_byte_q;

endmodule

### sim/tb.sv
// Testbench for adc_window_threshold_note_trigger: drives ADC status transactions,
// predicts the note-on bytes and checks every byte that leaves the block.
// Depends on awtnt_pkg and the adc_window_threshold_note_trigger RTL only.
`timescale 1ns / 1ps

module tb;
	import awtnt_pkg::*;

	localparam int SAMPLE_W      = 12;
	localparam int WINDOW_CAP    = 16;
	localparam int SETTLE_CYCLES = 6;    // status byte follows the closing sample through the queue and output register
	localparam int QUIET_LIMIT   = 4000; // cycles with no transaction on either side
	localparam int ITEM_TARGET   = 300;
	localparam int MAX_SEGMENTS  = 60;

	// Register indexes that the block has no register for
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [7:0] midi;
		logic       last;
	} midi_txn_t;

	// Tracks register contents and window state, and holds the bytes still owed
	class note_on_tracker;
		logic signed [15:0] threshold;
		logic [3:0]         discard;
		logic [4:0]         window;
		logic [7:0]         status;
		logic [6:0]         note;
		logic [6:0]         velocity;
		logic [3:0]         dropped;
		logic [4:0]         taken;
		logic signed [15:0] sum;
		bit                 held;
		midi_txn_t          bytes_due[$];
		int                 mismatches;
		int                 messages;
		int                 compared;

		function new();
			threshold  = THRESHOLD_RST;
			discard    = DISCARD_RST;
			window     = WINDOW_RST;
			status     = STATUS_RST;
			note       = NOTE_RST;
			velocity   = VELOCITY_RST;
			dropped    = '0;
			taken      = '0;
			sum        = '0;
			held       = 1'b0;
			mismatches = 0;
			messages   = 0;
			compared   = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_THRESHOLD: threshold = data;
				CFG_DISCARD:   discard   = data[3:0];
				CFG_WINDOW:    window    = data[4:0];
				CFG_STATUS:    status    = data[7:0];
				CFG_NOTE:      note      = data[6:0];
				CFG_VELOCITY:  velocity  = data[6:0];
				default: ;
			endcase
		endfunction

		// Note one accepted input transaction
		function void take_sample(logic ready, logic signed [SAMPLE_W-1:0] smp);
			int total;
			int span;
			if (!ready)
				return;
			if (dropped < discard) begin
				dropped++;
				return;
			end
			taken++;
			total = int'(sum) + int'(smp);
			if (total > 32767)
				total = 32767;
			if (total < -32768)
				total = -32768;
			sum  = total[15:0];
			span = window;
			if (span == 0)
				span = 1;
			if (span > WINDOW_CAP)
				span = WINDOW_CAP;
			if (taken >= span) begin
				if (sum < threshold && !held) begin
					bytes_due.push_back(midi_txn_t'{status, 1'b0});
					bytes_due.push_back(midi_txn_t'{{1'b0, note}, 1'b0});
					bytes_due.push_back(midi_txn_t'{{1'b0, velocity}, 1'b1});
					messages++;
					held = 1'b1;
				end
				// equal sum leaves the arming as it is
				if (sum > threshold)
					held = 1'b0;
				dropped = '0;
				taken   = '0;
				sum     = '0;
			end
		endfunction

		// Check one accepted output transaction against the oldest byte owed
		function void match_byte(logic [7:0] midi, logic last);
			midi_txn_t due;
			compared++;
			if (bytes_due.size() == 0) begin
				$error("unexpected byte: midi_byte %02h, last_byte %0b", midi, last);
				mismatches++;
				return;
			end
			due = bytes_due.pop_front();
			if (midi !== due.midi) begin
				$error("midi_byte: expected %02h, actual %02h", due.midi, midi);
				mismatches++;
			end
			if (last !== due.last) begin
				$error("last_byte: expected %0b, actual %0b", due.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_write;
	logic [CFG_INDEX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic                       conversion_ready;
	logic signed [SAMPLE_W-1:0] adc_sample;
	logic                       out_valid;
	logic                       out_stall;
	logic [7:0]                 midi_byte;
	logic                       last_byte;

	note_on_tracker tracker = new();

	int send_gap_pct;
	int stall_pct;
	int offered;
	int unready;

	adc_window_threshold_note_trigger #(
		.SAMPLE_BITS(SAMPLE_W),
		.MAX_WINDOW (WINDOW_CAP)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.conversion_ready(conversion_ready),
		.adc_sample      (adc_sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.midi_byte       (midi_byte),
		.last_byte       (last_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one input transaction, with a random gap ahead of it, and hold it
	// until the block takes it. Signals are read just after the edge, so they
	// still carry the values the block saw at that edge.
	task automatic send_item(input logic ready, input logic [SAMPLE_W-1:0] smp);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		conversion_ready <= ready;
		adc_sample       <= smp;
		do
			@(posedge clk);
		while (in_stall);
		tracker.take_sample(ready, smp);
		offered++;
		if (!ready)
			unready++;
	endtask

	// Hold the sender until every owed byte has left, then let the block settle:
	// a sample that closes no window may still be in flight
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (tracker.bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; bits above the register width carry junk, which the
	// block must drop. The caller lowers cfg_write after its last write.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value,
			input int keep);
		logic [15:0] mask;
		logic [15:0] data;
		mask = 16'((32'd1 << keep) - 1);
		data = (16'($urandom) & ~mask) | (value & mask);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.set_register(idx, data);
	endtask

	// Pick a fresh register setting; mostly short windows with a threshold near
	// the range that the window sum can reach, now and then the extremes
	task automatic shuffle_setup();
		logic [4:0]  win;
		logic [3:0]  drop;
		logic [15:0] thr;
		logic [7:0]  stat;
		logic [6:0]  key;
		logic [6:0]  vel;
		int          span;
		int          pick;
		wait_idle();
		pick = $urandom_range(0, 9);
		case (pick)
			0:       win = 5'd0;
			1:       win = 5'd16;
			2:       win = 5'd31;
			3:       win = 5'($urandom_range(17, 30));
			default: win = 5'($urandom_range(1, 4));
		endcase
		span = (win == 0) ? 1 : (win > WINDOW_CAP) ? WINDOW_CAP : win;
		pick = $urandom_range(0, 9);
		case (pick)
			0:       drop = 4'd15;
			1:       drop = 4'd0;
			default: drop = 4'($urandom_range(0, 3));
		endcase
		pick = $urandom_range(0, 9);
		case (pick)
			0:       thr = 16'h8000;
			1:       thr = 16'h7FFF;
			default: thr = 16'(int'($urandom_range(0, 2048 * span)) - 1024 * span);
		endcase
		pick = $urandom_range(0, 9);
		case (pick)
			0:       stat = 8'h80;
			1:       stat = 8'hFF;
			default: stat = 8'($urandom_range(128, 255));
		endcase
		key = ($urandom_range(0, 4) == 0) ? 7'h7F : 7'($urandom_range(0, 127));
		vel = ($urandom_range(0, 4) == 0) ? 7'h00 : 7'($urandom_range(0, 127));
		write_reg(CFG_WINDOW, 16'(win), 5);
		write_reg(CFG_DISCARD, 16'(drop), 4);
		write_reg(CFG_THRESHOLD, thr, 16);
		write_reg(CFG_STATUS, 16'(stat), 8);
		write_reg(CFG_NOTE, 16'(key), 7);
		write_reg(CFG_VELOCITY, 16'(vel), 7);
		// an unknown index must leave every register alone
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom), 16);
		cfg_write <= 1'b0;
	endtask

	// Receiver: take bytes, stall at random and watch for a hung block
	initial begin : receiver
		int quiet;
		quiet     = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
				tracker.match_byte(midi_byte, last_byte);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb: timeout after %0d quiet cycles", quiet);
				$display("tb: failure");
				$finish;
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	initial begin : stimulus
		int          seg;
		int          count;
		logic        ready;
		logic [11:0] smp;
		arst_n           <= 1'b0;
		cfg_write        <= 1'b0;
		cfg_index        <= CFG_THRESHOLD;
		cfg_data         <= '0;
		in_valid         <= 1'b0;
		conversion_ready <= 1'b0;
		adc_sample       <= '0;
		offered          = 0;
		unready          = 0;
		// first phase: sender rarely idles, receiver stalls often
		send_gap_pct     = 8;
		stall_pct        = 67;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: a not-ready transaction is ignored, four samples are
		// dropped, then a one-sample window at full negative scale fires
		send_item(1'b0, 12'h800);
		send_item(1'b1, 12'h7FF);
		send_item(1'b1, 12'h800);
		send_item(1'b1, 12'h000);
		send_item(1'b1, 12'hFFF);
		send_item(1'b1, 12'h800);

		// Two-sample windows, no drop, threshold zero; trigger is disarmed here
		wait_idle();
		write_reg(CFG_DISCARD, 16'd0, 4);
		write_reg(CFG_WINDOW, 16'd2, 5);
		write_reg(CFG_THRESHOLD, 16'd0, 16);
		cfg_write <= 1'b0;
		send_item(1'b1, 12'h7FF);   // sum equals threshold: no note, stays disarmed
		send_item(1'b1, 12'h801);
		send_item(1'b1, 12'h001);   // sum above threshold: re-arm
		send_item(1'b1, 12'h000);
		send_item(1'b1, 12'hFFF);   // sum just below: note fires
		send_item(1'b1, 12'h000);

		// Window length zero acts as one; lowest threshold re-arms on anything
		wait_idle();
		write_reg(CFG_THRESHOLD, 16'h8000, 16);
		write_reg(CFG_WINDOW, 16'd0, 5);
		write_reg(CFG_STATUS, 16'h0080, 8);
		write_reg(CFG_NOTE, 16'h0000, 7);
		write_reg(CFG_VELOCITY, 16'h0000, 7);
		cfg_write <= 1'b0;
		send_item(1'b1, 12'h7FF);
		send_item(1'b1, 12'h800);

		// Highest threshold: a full positive sample still fires
		wait_idle();
		write_reg(CFG_THRESHOLD, 16'h7FFF, 16);
		cfg_write <= 1'b0;
		send_item(1'b1, 12'h7FF);

		// Random segments, each under its own register setting, until the item
		// target is reached
		for (seg = 0; seg < MAX_SEGMENTS && offered < ITEM_TARGET; seg++) begin
			if (seg == 4) begin
				// second phase: sender idles often, receiver rarely stalls
				send_gap_pct = 67;
				stall_pct    = 8;
			end else if (seg == 8) begin
				// last phase: full rate on both sides
				send_gap_pct = 0;
				stall_pct    = 0;
			end
			shuffle_setup();
			count = $urandom_range(20, 30);
			repeat (count) begin
				ready = ($urandom_range(0, 9) != 0);
				case ($urandom_range(0, 9))
					0:       smp = 12'h800;
					1:       smp = 12'h7FF;
					default: smp = 12'($urandom);
				endcase
				send_item(ready, smp);
			end
		end

		wait_idle();
		$display("tb: %0d input transactions (%0d not ready), %0d note-on messages, %0d bytes",
			offered, unready, tracker.messages, tracker.compared);
		$display("tb: windows of up to %0d samples, all three idling phases",
			WINDOW_CAP);
		if (tracker.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
hw/rtl/awtnt_pkg.sv
hw/rtl/awtnt_front.sv
hw/rtl/awtnt_queue.sv
hw/rtl/awtnt_back.sv
hw/rtl/adc_window_threshold_note_trigger.sv
sim/tb.sv
